/* design/dcf_pkg.sv */
// shared types and constants for the duty to cycle fraction core
package dcf_pkg;

	localparam int ON_W     = 6;
	localparam int OFF_W    = 6;
	localparam int STATUS_W = 2;

	localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_CLAMPED = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_NO_LOAD = 2'd2;

	typedef struct packed {
		logic                valid;
		logic [STATUS_W-1:0] status;
	} ctl_t;

endpackage

/* design/dcf_if.sv */
// valid/ready channel interfaces for request and response
interface dcf_req_if #(
	parameter int W = 16
);
	logic         valid;
	logic         ready;
	logic [W-1:0] target_power;
	logic [W-1:0] load_power;

	modport source (output valid, output target_power, output load_power, input ready);
	modport sink   (input valid, input target_power, input load_power, output ready);
endinterface

interface dcf_rsp_if;
	logic                         valid;
	logic                         ready;
	logic [dcf_pkg::ON_W-1:0]     on_count;
	logic [dcf_pkg::OFF_W-1:0]    off_count;
	logic [dcf_pkg::STATUS_W-1:0] status;

	modport source (output valid, output on_count, output off_count, output status, input ready);
	modport sink   (input valid, input on_count, input off_count, input status, output ready);
endinterface

/* design/duty_to_cycle_fraction_core.sv */
// top level: entry stage, denominator cell chain and response register
//
//  channel | dir | payload                           | transaction
//  req     | in  | target_power, load_power          | valid && ready
//  rsp     | out | on_count, off_count, status       | valid && ready
//
// one request per cycle unless stalled, through entry, cell chain and rsp register
// one cell per denominator from 2 to MAX_DENOM, each a register stage
// whole chain advances together; rsp.ready low with a response held stalls req.ready
// reset clears the stage valid bits only
module duty_to_cycle_fraction_core #(
	parameter int MAX_DENOM  = 59,
	parameter int POWER_BITS = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	dcf_req_if.sink          req,
	dcf_rsp_if.source        rsp
);

	localparam int W  = POWER_BITS;
	localparam int DW = (MAX_DENOM < 2) ? 1 : $clog2(MAX_DENOM + 1);

	dcf_pkg::ctl_t ctl      [MAX_DENOM];
	logic [W-1:0]  tgt      [MAX_DENOM];
	logic [W-1:0]  load     [MAX_DENOM];
	logic [W-1:0]  rem      [MAX_DENOM];
	logic [DW-1:0] quo      [MAX_DENOM];
	logic [W-1:0]  best_rem [MAX_DENOM];
	logic [DW-1:0] best_d   [MAX_DENOM];
	logic [DW-1:0] best_quo [MAX_DENOM];

	logic          adv;
	logic          rsp_valid_q;
	logic [DW+5:0] on_ext;
	logic [DW+5:0] off_ext;
	logic [dcf_pkg::ON_W-1:0]     on_q;
	logic [dcf_pkg::OFF_W-1:0]    off_q;
	logic [dcf_pkg::STATUS_W-1:0] status_q;

	assign adv       = !rsp_valid_q || rsp.ready;
	assign req.ready = adv;

	dcf_entry #(.W(W), .DW(DW)) u_entry (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.valid        (req.valid),
		.target_power (req.target_power),
		.load_power   (req.load_power),
		.ctl_s1       (ctl[0]),
		.tgt_s1       (tgt[0]),
		.load_s1      (load[0]),
		.rem_s1       (rem[0]),
		.quo_s1       (quo[0]),
		.best_rem_s1  (best_rem[0]),
		.best_d_s1    (best_d[0]),
		.best_quo_s1  (best_quo[0])
	);

	for (genvar k = 1; k < MAX_DENOM; k++) begin : g_cell
		dcf_cell #(.W(W), .DW(DW), .D(k + 1)) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.adv         (adv),
			.ctl         (ctl[k-1]),
			.tgt         (tgt[k-1]),
			.load        (load[k-1]),
			.rem         (rem[k-1]),
			.quo         (quo[k-1]),
			.best_rem    (best_rem[k-1]),
			.best_d      (best_d[k-1]),
			.best_quo    (best_quo[k-1]),
			.ctl_s1      (ctl[k]),
			.tgt_s1      (tgt[k]),
			.load_s1     (load[k]),
			.rem_s1      (rem[k]),
			.quo_s1      (quo[k]),
			.best_rem_s1 (best_rem[k]),
			.best_d_s1   (best_d[k]),
			.best_quo_s1 (best_quo[k])
		);
	end

	always_comb begin
		on_ext  = {6'd0, best_quo[MAX_DENOM-1]};
		off_ext = {6'd0, DW'(best_d[MAX_DENOM-1] - best_quo[MAX_DENOM-1])};
		if (ctl[MAX_DENOM-1].status == dcf_pkg::STATUS_NO_LOAD) begin
			on_ext  = '0;
			off_ext = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (adv) begin
			rsp_valid_q <= ctl[MAX_DENOM-1].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			on_q     <= on_ext[dcf_pkg::ON_W-1:0];
			off_q    <= off_ext[dcf_pkg::OFF_W-1:0];
			status_q <= ctl[MAX_DENOM-1].status;
		end
	end

	assign rsp.valid     = rsp_valid_q;
	assign rsp.on_count  = on_q;
	assign rsp.off_count = off_q;
	assign rsp.status    = status_q;

	a_no_load_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && status_q == dcf_pkg::STATUS_NO_LOAD |-> on_q == '0 && off_q == '0)
		else $error("zero load response carries nonzero counts");

	a_clamp_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && status_q == dcf_pkg::STATUS_CLAMPED
		|-> on_q == dcf_pkg::ON_W'(1) && off_q == '0)
		else $error("clamped response is not full on");

	a_stall_blocks_req: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp.ready |-> !req.ready)
		else $error("request taken while response stalled");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> status_q == dcf_pkg::STATUS_OK || status_q == dcf_pkg::STATUS_CLAMPED
		|| status_q == dcf_pkg::STATUS_NO_LOAD)
		else $error("response status code out of range");

endmodule

/* design/dcf_entry.sv */
// entry stage: clamp, zero load flag and the terms for denominator one
module dcf_entry #(
	parameter int W  = 16,
	parameter int DW = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  logic          valid,
	input  logic [W-1:0]  target_power,
	input  logic [W-1:0]  load_power,
	output dcf_pkg::ctl_t ctl_s1,
	output logic [W-1:0]  tgt_s1,
	output logic [W-1:0]  load_s1,
	output logic [W-1:0]  rem_s1,
	output logic [DW-1:0] quo_s1,
	output logic [W-1:0]  best_rem_s1,
	output logic [DW-1:0] best_d_s1,
	output logic [DW-1:0] best_quo_s1
);

	logic [W-1:0]                  tgt;
	logic                          full;
	logic [dcf_pkg::STATUS_W-1:0]  status;
	logic                          valid_s1;
	logic [dcf_pkg::STATUS_W-1:0]  status_s1;

	always_comb begin
		tgt    = target_power;
		status = dcf_pkg::STATUS_OK;
		if (load_power == '0) begin
			status = dcf_pkg::STATUS_NO_LOAD;
			tgt    = '0;
		end else if (target_power > load_power) begin
			status = dcf_pkg::STATUS_CLAMPED;
			tgt    = load_power;
		end
		full = (tgt == load_power);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s1   <= status;
			tgt_s1      <= tgt;
			load_s1     <= load_power;
			rem_s1      <= full ? '0 : tgt;
			quo_s1      <= DW'(full);
			best_rem_s1 <= full ? '0 : tgt;
			best_d_s1   <= DW'(1);
			best_quo_s1 <= DW'(full);
		end
	end

	assign ctl_s1 = '{valid: valid_s1, status: status_s1};

endmodule

/* design/dcf_cell.sv */
// one denominator cell: steps the remainder and quotient, keeps the best so far
module dcf_cell #(
	parameter int W  = 16,
	parameter int DW = 6,
	parameter int D  = 2
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          adv,
	input  dcf_pkg::ctl_t ctl,
	input  logic [W-1:0]  tgt,
	input  logic [W-1:0]  load,
	input  logic [W-1:0]  rem,
	input  logic [DW-1:0] quo,
	input  logic [W-1:0]  best_rem,
	input  logic [DW-1:0] best_d,
	input  logic [DW-1:0] best_quo,
	output dcf_pkg::ctl_t ctl_s1,
	output logic [W-1:0]  tgt_s1,
	output logic [W-1:0]  load_s1,
	output logic [W-1:0]  rem_s1,
	output logic [DW-1:0] quo_s1,
	output logic [W-1:0]  best_rem_s1,
	output logic [DW-1:0] best_d_s1,
	output logic [DW-1:0] best_quo_s1
);

	localparam logic [DW-1:0] DEN = DW'(D);

	logic [W:0]    sum;
	logic          wrap;
	logic [W-1:0]  nrem;
	logic [DW-1:0] nquo;
	logic          better;
	logic          valid_s1;
	logic [dcf_pkg::STATUS_W-1:0] status_s1;

	always_comb begin
		sum    = {1'b0, rem} + {1'b0, tgt};
		wrap   = (sum >= {1'b0, load});
		nrem   = wrap ? W'(sum - {1'b0, load}) : sum[W-1:0];
		nquo   = quo + DW'(wrap);
		better = (nrem < best_rem);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			status_s1   <= ctl.status;
			tgt_s1      <= tgt;
			load_s1     <= load;
			rem_s1      <= nrem;
			quo_s1      <= nquo;
			best_rem_s1 <= better ? nrem : best_rem;
			best_d_s1   <= better ? DEN : best_d;
			best_quo_s1 <= better ? nquo : best_quo;
		end
	end

	assign ctl_s1 = '{valid: valid_s1, status: status_s1};

endmodule
